/* hdl/edfbs_pkg.sv */
// Shared types, constants and per-bucket tables for the EDF bucket scheduler.
// No dependencies.
package edfbs_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned BudW  = 16;
  localparam logic [2:0]  NilId = 3'd7;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [1:0] ReqRunnable = 2'd0;
  localparam logic [1:0] ReqEmpty    = 2'd1;
  localparam logic [1:0] ReqSelect   = 2'd2;
  localparam logic [1:0] ReqNoop     = 2'd3;

  localparam logic [1:0] ReasonEdf  = 2'd0;
  localparam logic [1:0] ReasonStarve = 2'd1;
  localparam logic [1:0] ReasonWarp = 2'd2;

  typedef logic [2:0] id_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,        // latch request
    OP_RUN,         // runnable bookkeeping, clear links, set deadline
    OP_INS,         // root = merge(root, b)
    OP_EMPTY,       // empty bookkeeping
    OP_RNR_UNLINK,  // remove_non_root unlink step
    OP_ROOT_DETACH, // remove_root: set up meld of child of b
    OP_MELD1,       // one pass-one pair step
    OP_MELD2,       // one pass-two merge step
    OP_MELD_DONE,   // apply meld result
    OP_SEL_EVAL,    // compute select decision for root
    OP_STARVE_END,  // clear starvation, start deadline update
    OP_UPD_DL,      // compare new deadline, start key increase
    OP_SEL_FINISH,  // record select outcome
    OP_WARP_DROP,   // drop warp candidate
    OP_WARP_TAKE,   // set warp end, start deadline update
    OP_REINS        // root = merge(root, bucket under update)
  } op_t;

  typedef struct packed {
    logic sel_done;   // SEL_EVAL: result known
    logic starve_exp; // SEL_EVAL: starvation window over
    logic warp_take;  // SEL_EVAL: warp bucket selected
    logic warp_drop;  // SEL_EVAL: warp window expired
    logic need_upd;   // SEL_EVAL result needs deadline update
    logic bad;        // request rejected
    logic is_root;    // bucket is heap root
    logic has_child;  // bucket has a child
    logic key_up;     // deadline increased
    logic meld_p1_more;
    logic meld_p2_more;
    logic empty_heap;
  } stat_t;

  function automatic logic [TimeW-1:0] lat_of(input id_t b);
    case (b)
      3'd0: lat_of = 64'd0;
      3'd1: lat_of = 64'd37500;
      3'd2: lat_of = 64'd75000;
      3'd3: lat_of = 64'd150000;
      default: lat_of = 64'd250000;
    endcase
  endfunction

  function automatic logic [BudW-1:0] warp_of(input id_t b);
    case (b)
      3'd0: warp_of = 16'd8000;
      3'd1: warp_of = 16'd4000;
      3'd2: warp_of = 16'd2000;
      3'd3: warp_of = 16'd1000;
      default: warp_of = 16'd0;
    endcase
  endfunction

  function automatic logic [TimeW-1:0] quant_of(input id_t b);
    case (b)
      3'd0: quant_of = 64'd10000;
      3'd1: quant_of = 64'd8000;
      3'd2: quant_of = 64'd6000;
      3'd3: quant_of = 64'd4000;
      default: quant_of = 64'd2000;
    endcase
  endfunction

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

/* hdl/edfbs_if.sv */
// Valid/ready channel interfaces for requests and results.
// No dependencies.
interface edfbs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  bucket_id;
  logic [63:0] time_us;
  modport source (output valid, req_type, bucket_id, time_us, input ready);
  modport sink (input valid, req_type, bucket_id, time_us, output ready);
endinterface

interface edfbs_res_if;
  logic       valid;
  logic       ready;
  logic       sel_valid;
  logic [2:0] sel_bucket;
  logic [1:0] sel_reason;
  logic       req_error;
  modport source (output valid, sel_valid, sel_bucket, sel_reason, req_error, input ready);
  modport sink (input valid, sel_valid, sel_bucket, sel_reason, req_error, output ready);
endinterface

/* hdl/edf_bucket_scheduler_warp_starvation.sv */
// Earliest-deadline bucket scheduler with warp and starvation avoidance.
// Depends on edfbs_pkg, edfbs_if, edfbs_ctrl and edfbs_datapath.
//
// One request is handled at a time; the next request beat is accepted the
// cycle after the result beat is taken. A runnable request inserts the bucket
// into the pairing heap; a rejected request or an unused type goes straight
// to the result. An empty request removes the bucket and melds its children:
// pass one links one pair per cycle, pass two merges the pairs back into one
// heap. A select ends without a deadline update when the heap is empty or no
// deadline moves; else the deadline is checked and, when it rises, the bucket
// is re-sorted, and a warp first sets the warp end. Each starvation window
// that has run out forces a deadline update before the retry, and each lapsed
// warp budget is dropped before it. A result beat that waits for ready stalls
// the block for as long as it waits.
module edf_bucket_scheduler_warp_starvation #(
  parameter int unsigned NUM_BUCKETS = 5
) (
  input logic clk,
  input logic rst,
  edfbs_req_if.sink   req,
  edfbs_res_if.source res
);
  import edfbs_pkg::*;

  op_t   op;
  stat_t stat;
  logic [1:0] req_type_q;

  edfbs_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .req_type_q, .stat, .op
  );

  edfbs_datapath #(.NB(NUM_BUCKETS)) u_dp (
    .clk, .rst, .op,
    .in_type(req.req_type), .in_bucket(req.bucket_id), .in_time(req.time_us),
    .stat, .req_type_q,
    .sel_valid(res.sel_valid), .sel_bucket(res.sel_bucket),
    .sel_reason(res.sel_reason), .req_error(res.req_error)
  );

endmodule

/* hdl/edfbs_datapath.sv */
// Scheduler state, pairing heap links and the datapath steps that change them.
// Depends on edfbs_pkg.
module edfbs_datapath #(
  parameter int unsigned NB = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  edfbs_pkg::op_t  op,
  input  logic [1:0]      in_type,
  input  logic [2:0]      in_bucket,
  input  logic [63:0]     in_time,
  output edfbs_pkg::stat_t stat,
  output logic [1:0]      req_type_q,
  output logic            sel_valid,
  output logic [2:0]      sel_bucket,
  output logic [1:0]      sel_reason,
  output logic            req_error
);
  import edfbs_pkg::*;

  logic [TimeW-1:0] deadline [NB];
  logic [TimeW-1:0] starve_start [NB];
  logic [TimeW-1:0] warp_end [NB];
  logic [BudW-1:0]  warp_budget [NB];
  logic [NB-1:0]    runnable_map, warp_map, starving;
  id_t heap_root;
  id_t heap_child [NB];
  id_t heap_next [NB];
  id_t heap_prev [NB];

  id_t              bid;
  logic [TimeW-1:0] t;
  // Meld registers.
  id_t meld_e, meld_list, meld_res;
  id_t meld_owner;   // bucket whose child list is melded
  logic meld_nonroot; // meld result merges into root
  id_t upd_b;        // bucket under deadline update
  id_t wi_q;         // warp candidate

  function automatic logic okid(input id_t i);
    okid = ({1'b0, i} < 4'(NB));
  endfunction

  function automatic id_t lsb(input logic [NB-1:0] m);
    id_t r;
    r = NilId;
    for (int i = NB - 1; i >= 0; i--) if (m[i]) r = id_t'(i);
    lsb = r;
  endfunction

  // Merge decision (combinational, shared by all merge sites).
  id_t mg_a, mg_b, mg_par, mg_chi;
  logic mg_link;
  always_comb begin
    mg_link = 1'b0;
    mg_par  = mg_b;
    mg_chi  = mg_a;
    if (!okid(mg_a)) begin
      mg_par = mg_b;
    end else if (!okid(mg_b) || mg_a == mg_b) begin
      mg_par = mg_a;
    end else begin
      mg_link = 1'b1;
      if (deadline[mg_a[$clog2(NB)-1:0]] < deadline[mg_b[$clog2(NB)-1:0]]) begin
        mg_par = mg_a;
        mg_chi = mg_b;
      end else begin
        mg_par = mg_b;
        mg_chi = mg_a;
      end
    end
  end

  // Merge operand selection.
  id_t m1_b;
  always_comb begin
    m1_b = okid(meld_e) ? heap_next[meld_e[$clog2(NB)-1:0]] : NilId;
    case (op)
      OP_INS:      begin mg_a = heap_root; mg_b = bid; end
      OP_MELD1:    begin mg_a = meld_e; mg_b = m1_b; end
      OP_MELD2:    begin mg_a = meld_res; mg_b = meld_list; end
      OP_MELD_DONE:begin mg_a = heap_root; mg_b = meld_res; end
      default:     begin mg_a = heap_root; mg_b = upd_b; end
    endcase
  end

  // Select evaluation.
  id_t e, hi, wi;
  logic [TimeW-1:0] nd_upd, st_lim, we_sum;
  logic starve_over, can_warp, in_window;
  always_comb begin
    e  = heap_root;
    hi = lsb(runnable_map);
    wi = lsb(warp_map);
    st_lim = '0;
    starve_over = 1'b0;
    can_warp = okid(wi) && wi < e;
    in_window = 1'b0;
    if (okid(e)) begin
      st_lim = sat_add(starve_start[e[$clog2(NB)-1:0]], quant_of(e));
      starve_over = starving[e[$clog2(NB)-1:0]] && t >= st_lim;
    end
    if (okid(wi))
      in_window = warp_end[wi[$clog2(NB)-1:0]] == TimeMax ||
                  warp_end[wi[$clog2(NB)-1:0]] > t;
    nd_upd = okid(upd_b) ? sat_add(t, lat_of(upd_b)) : '0;
    we_sum = okid(wi_q) ? sat_add(t, {48'd0, warp_budget[wi_q[$clog2(NB)-1:0]]}) : '0;
  end

  always_comb begin
    stat = '0;
    stat.empty_heap = !okid(heap_root);
    stat.starve_exp = okid(e) && starve_over;
    stat.sel_done   = okid(e) && !starve_over && !can_warp;
    stat.warp_take  = okid(e) && !starve_over && can_warp && in_window;
    stat.warp_drop  = okid(e) && !starve_over && can_warp && !in_window;
    stat.need_upd   = okid(e) && !starve_over && !can_warp &&
                      !starving[e[$clog2(NB)-1:0]] && !(hi < e);
    stat.bad = !okid(bid) ||
               (req_type_q == ReqRunnable ? runnable_map[bid[$clog2(NB)-1:0]]
                                          : !runnable_map[bid[$clog2(NB)-1:0]]);
    stat.is_root   = heap_root == (op == OP_UPD_DL ? upd_b : bid);
    stat.has_child = okid(upd_b) && okid(heap_child[upd_b[$clog2(NB)-1:0]]);
    stat.key_up    = okid(upd_b) && nd_upd > deadline[upd_b[$clog2(NB)-1:0]];
    stat.meld_p1_more = okid(m1_b) && okid(heap_next[m1_b[$clog2(NB)-1:0]]);
    stat.meld_p2_more = okid(meld_list) && okid(heap_prev[meld_list[$clog2(NB)-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        deadline[i] <= '0;
        starve_start[i] <= '0;
        warp_end[i] <= TimeMax;
        warp_budget[i] <= warp_of(id_t'(i));
        heap_child[i] <= NilId;
        heap_next[i] <= NilId;
        heap_prev[i] <= NilId;
      end
      runnable_map <= '0;
      warp_map <= '0;
      starving <= '0;
      heap_root <= NilId;
      sel_valid <= 1'b0; sel_bucket <= '0; sel_reason <= '0; req_error <= 1'b0;
      meld_e <= NilId; meld_list <= NilId; meld_res <= NilId;
      meld_owner <= NilId; meld_nonroot <= 1'b0; upd_b <= NilId; wi_q <= NilId;
      bid <= '0; t <= '0; req_type_q <= ReqRunnable;
    end else begin
      // Generic link update for a merge at this step.
      if (mg_link && (op == OP_INS || op == OP_MELD1 || op == OP_MELD2 ||
                      (op == OP_MELD_DONE && meld_nonroot) || op == OP_REINS)) begin
        heap_next[mg_chi[$clog2(NB)-1:0]] <= heap_child[mg_par[$clog2(NB)-1:0]];
        heap_prev[mg_chi[$clog2(NB)-1:0]] <= mg_par;
        if (okid(heap_child[mg_par[$clog2(NB)-1:0]]))
          heap_prev[heap_child[mg_par[$clog2(NB)-1:0]][$clog2(NB)-1:0]] <= mg_chi;
        heap_child[mg_par[$clog2(NB)-1:0]] <= mg_chi;
        heap_next[mg_par[$clog2(NB)-1:0]] <= NilId;
        if (op != OP_MELD1) heap_prev[mg_par[$clog2(NB)-1:0]] <= NilId;
      end
      case (op)
        OP_LOAD: begin
          bid <= in_bucket; t <= in_time; req_type_q <= in_type;
          sel_valid <= 1'b0; sel_bucket <= '0; sel_reason <= '0; req_error <= 1'b0;
        end
        OP_RUN: begin
          if (stat.bad) req_error <= 1'b1;
          else begin
            runnable_map[bid[$clog2(NB)-1:0]] <= 1'b1;
            if (!starving[bid[$clog2(NB)-1:0]])
              deadline[bid[$clog2(NB)-1:0]] <= sat_add(t, lat_of(bid));
            heap_child[bid[$clog2(NB)-1:0]] <= NilId;
            heap_next[bid[$clog2(NB)-1:0]] <= NilId;
            heap_prev[bid[$clog2(NB)-1:0]] <= NilId;
            if (warp_budget[bid[$clog2(NB)-1:0]] != '0)
              warp_map[bid[$clog2(NB)-1:0]] <= 1'b1;
          end
        end
        OP_INS: heap_root <= mg_par;
        OP_REINS: heap_root <= mg_par;
        OP_EMPTY: begin
          if (stat.bad) req_error <= 1'b1;
          else begin
            runnable_map[bid[$clog2(NB)-1:0]] <= 1'b0;
            warp_map[bid[$clog2(NB)-1:0]] <= 1'b0;
            if (warp_end[bid[$clog2(NB)-1:0]] != TimeMax) begin
              if (warp_end[bid[$clog2(NB)-1:0]] <= t)
                warp_budget[bid[$clog2(NB)-1:0]] <= '0;
              else if (warp_end[bid[$clog2(NB)-1:0]] - t > 64'hFFFF)
                warp_budget[bid[$clog2(NB)-1:0]] <= 16'hFFFF;
              else
                warp_budget[bid[$clog2(NB)-1:0]] <=
                  BudW'(warp_end[bid[$clog2(NB)-1:0]] - t);
            end
            upd_b <= bid;
          end
        end
        OP_RNR_UNLINK: begin
          // upd_b names the bucket being detached from the middle of the heap
          if (okid(heap_prev[upd_b[$clog2(NB)-1:0]])) begin
            if (heap_child[heap_prev[upd_b[$clog2(NB)-1:0]][$clog2(NB)-1:0]] == upd_b)
              heap_child[heap_prev[upd_b[$clog2(NB)-1:0]][$clog2(NB)-1:0]] <=
                heap_next[upd_b[$clog2(NB)-1:0]];
            else
              heap_next[heap_prev[upd_b[$clog2(NB)-1:0]][$clog2(NB)-1:0]] <=
                heap_next[upd_b[$clog2(NB)-1:0]];
            if (okid(heap_next[upd_b[$clog2(NB)-1:0]]))
              heap_prev[heap_next[upd_b[$clog2(NB)-1:0]][$clog2(NB)-1:0]] <=
                heap_prev[upd_b[$clog2(NB)-1:0]];
          end
          heap_next[upd_b[$clog2(NB)-1:0]] <= NilId;
          heap_prev[upd_b[$clog2(NB)-1:0]] <= NilId;
          meld_e <= heap_child[upd_b[$clog2(NB)-1:0]];
          meld_list <= NilId; meld_res <= NilId;
          meld_owner <= upd_b; meld_nonroot <= 1'b1;
        end
        OP_ROOT_DETACH: begin
          meld_e <= heap_child[upd_b[$clog2(NB)-1:0]];
          meld_list <= NilId; meld_res <= NilId;
          meld_owner <= upd_b; meld_nonroot <= 1'b0;
        end
        OP_MELD1: begin
          if (!okid(m1_b)) begin
            if (okid(meld_e)) heap_prev[meld_e[$clog2(NB)-1:0]] <= meld_list;
            meld_list <= meld_e;
          end else begin
            // the merge parent takes the list link
            heap_prev[mg_par[$clog2(NB)-1:0]] <= meld_list;
            meld_list <= mg_par;
            meld_e <= heap_next[m1_b[$clog2(NB)-1:0]];
          end
        end
        OP_MELD2: begin
          meld_res <= mg_par;
          meld_list <= okid(meld_list) ? heap_prev[meld_list[$clog2(NB)-1:0]] : NilId;
        end
        OP_MELD_DONE: begin
          heap_child[meld_owner[$clog2(NB)-1:0]] <= NilId;
          if (meld_nonroot) heap_root <= mg_par;
          else heap_root <= meld_res;
          if (mg_link && meld_nonroot && mg_par == meld_owner)
            heap_child[meld_owner[$clog2(NB)-1:0]] <= mg_chi;
        end
        OP_SEL_EVAL: begin
          upd_b <= stat.warp_take ? wi : e;
          wi_q <= wi;
          if (stat.starve_exp) begin
            starving[e[$clog2(NB)-1:0]] <= 1'b0;
            starve_start[e[$clog2(NB)-1:0]] <= '0;
          end else if (stat.sel_done) begin
            sel_valid <= 1'b1; sel_bucket <= e;
            if (!starving[e[$clog2(NB)-1:0]]) begin
              if (hi < e) begin
                starving[e[$clog2(NB)-1:0]] <= 1'b1;
                starve_start[e[$clog2(NB)-1:0]] <= t;
                sel_reason <= ReasonStarve;
              end else begin
                sel_reason <= ReasonEdf;
                warp_budget[e[$clog2(NB)-1:0]] <= warp_of(e);
                warp_end[e[$clog2(NB)-1:0]] <= TimeMax;
                if (warp_of(e) != '0) warp_map[e[$clog2(NB)-1:0]] <= 1'b1;
              end
            end else sel_reason <= ReasonStarve;
          end else if (stat.warp_take) begin
            sel_valid <= 1'b1; sel_bucket <= wi; sel_reason <= ReasonWarp;
          end else if (stat.warp_drop) begin
            warp_budget[wi[$clog2(NB)-1:0]] <= '0;
            warp_map[wi[$clog2(NB)-1:0]] <= 1'b0;
          end
        end
        OP_WARP_TAKE: begin
          if (warp_end[wi_q[$clog2(NB)-1:0]] == TimeMax)
            warp_end[wi_q[$clog2(NB)-1:0]] <= (we_sum == TimeMax) ? TimeMax - 1 : we_sum;
        end
        OP_UPD_DL: begin
          if (stat.key_up) deadline[upd_b[$clog2(NB)-1:0]] <= nd_upd;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/edfbs_ctrl.sv */
// Sequencer for request handling, heap maintenance and the select retry loop.
// Depends on edfbs_pkg.
module edfbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       req_type_q,
  input  edfbs_pkg::stat_t stat,
  output edfbs_pkg::op_t   op
);
  import edfbs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RUN_INS, S_EMPTY, S_REMOVE, S_UNLINK, S_DETACH,
    S_MELD1, S_MELD2, S_MELD_DONE, S_SEL, S_UPD, S_REINS, S_WARP, S_DONE
  } state_t;

  state_t state;
  logic   remove_for_upd; // meld belongs to a key increase, reinsert after
  logic   upd_then_done;  // deadline update ends the select

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DONE;

  always_comb begin
    case (state)
      S_IDLE:      op = in_valid ? OP_LOAD : OP_NONE;
      S_DISPATCH:  op = req_type_q == ReqRunnable ? OP_RUN :
                        req_type_q == ReqEmpty ? OP_EMPTY : OP_NONE;
      S_RUN_INS:   op = OP_INS;
      S_UNLINK:    op = OP_RNR_UNLINK;
      S_DETACH:    op = OP_ROOT_DETACH;
      S_MELD1:     op = OP_MELD1;
      S_MELD2:     op = OP_MELD2;
      S_MELD_DONE: op = OP_MELD_DONE;
      S_SEL:       op = OP_SEL_EVAL;
      S_WARP:      op = OP_WARP_TAKE;
      S_UPD:       op = OP_UPD_DL;
      S_REINS:     op = OP_REINS;
      default:     op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      remove_for_upd <= 1'b0;
      upd_then_done <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (req_type_q == ReqRunnable) state <= stat.bad ? S_DONE : S_RUN_INS;
          else if (req_type_q == ReqEmpty) state <= stat.bad ? S_DONE : S_EMPTY;
          else if (req_type_q == ReqSelect) state <= S_SEL;
          else state <= S_DONE;
        end
        S_RUN_INS: state <= S_DONE;
        S_EMPTY: begin
          remove_for_upd <= 1'b0;
          state <= S_REMOVE;
        end
        S_REMOVE: state <= stat.is_root ? S_DETACH : S_UNLINK;
        S_UNLINK: state <= S_MELD1;
        S_DETACH: state <= S_MELD1;
        S_MELD1: state <= stat.meld_p1_more ? S_MELD1 : S_MELD2;
        S_MELD2: state <= stat.meld_p2_more ? S_MELD2 : S_MELD_DONE;
        S_MELD_DONE: state <= remove_for_upd ? S_REINS : S_DONE;
        S_SEL: begin
          if (stat.empty_heap) state <= S_DONE;
          else if (stat.starve_exp) begin
            upd_then_done <= 1'b0; state <= S_UPD;
          end else if (stat.sel_done) begin
            upd_then_done <= 1'b1;
            state <= stat.need_upd ? S_UPD : S_DONE;
          end else if (stat.warp_take) begin
            upd_then_done <= 1'b1; state <= S_WARP;
          end else state <= S_SEL;
        end
        S_WARP: state <= S_UPD;
        S_UPD: begin
          if (!stat.key_up) state <= upd_then_done ? S_DONE : S_SEL;
          else if (!stat.is_root) begin
            remove_for_upd <= 1'b1; state <= S_UNLINK;
          end else if (stat.has_child) begin
            remove_for_upd <= 1'b1; state <= S_DETACH;
          end else state <= upd_then_done ? S_DONE : S_SEL;
        end
        S_REINS: begin
          remove_for_upd <= 1'b0;
          state <= upd_then_done ? S_DONE : S_SEL;
        end
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/edfbs_sched_model.sv */
// Bit-accurate model of the EDF bucket scheduler used by the test top.
// Depends on edfbs_pkg for the request and reason codes.
`timescale 1ns / 100ps
package edfbs_sched_model;
  import edfbs_pkg::*;

  localparam int NB = 5;

  typedef struct packed {
    logic       sel_valid;
    logic [2:0] sel_bucket;
    logic [1:0] sel_reason;
    logic       req_error;
  } outcome_t;

  logic [63:0] dl [NB];
  logic        run_f [NB];
  logic        starv_f [NB];
  logic [63:0] starv_t0 [NB];
  logic [15:0] budget [NB];
  logic [63:0] wend [NB];
  logic [NB-1:0] run_map, warp_map;
  logic [2:0] root;
  logic [2:0] kid [NB];
  logic [2:0] nxt [NB];
  logic [2:0] prv [NB];

  function automatic logic [63:0] lat(int b);
    case (b)
      0: return 64'd0;
      1: return 64'd37500;
      2: return 64'd75000;
      3: return 64'd150000;
      default: return 64'd250000;
    endcase
  endfunction

  function automatic logic [15:0] wbud(int b);
    case (b)
      0: return 16'd8000;
      1: return 16'd4000;
      2: return 16'd2000;
      3: return 16'd1000;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [63:0] quantum(int b);
    case (b)
      0: return 64'd10000;
      1: return 64'd8000;
      2: return 64'd6000;
      3: return 64'd4000;
      default: return 64'd2000;
    endcase
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic bit valid_id(logic [2:0] i);
    return i < NB;
  endfunction

  function automatic logic [2:0] lowest(logic [NB-1:0] m);
    for (int i = 0; i < NB; i++) if (m[i]) return 3'(i);
    return NilId;
  endfunction

  function automatic logic [2:0] link(logic [2:0] a, logic [2:0] b);
    logic [2:0] p, c;
    if (!valid_id(a)) return b;
    if (!valid_id(b) || a == b) return a;
    p = a; c = b;
    if (!(dl[a] < dl[b])) begin p = b; c = a; end
    nxt[c] = kid[p];
    prv[c] = p;
    if (valid_id(kid[p])) prv[kid[p]] = c;
    kid[p] = c;
    nxt[p] = NilId;
    prv[p] = NilId;
    return p;
  endfunction

  function automatic logic [2:0] pair_up(logic [2:0] e);
    logic [2:0] lst, res, a, b, p;
    lst = NilId; res = NilId;
    if (!valid_id(e)) return NilId;
    do begin
      a = e;
      b = nxt[a];
      if (!valid_id(b)) begin prv[a] = lst; lst = a; break; end
      e = nxt[b];
      p = link(a, b);
      prv[p] = lst;
      lst = p;
    end while (valid_id(e));
    do begin
      e = prv[lst];
      res = link(res, lst);
      lst = e;
    end while (valid_id(lst));
    return res;
  endfunction

  function automatic void pop_root(logic [2:0] e);
    if (valid_id(kid[e])) begin
      root = pair_up(kid[e]);
      kid[e] = NilId;
    end else root = NilId;
  endfunction

  function automatic void unlink(logic [2:0] e);
    logic [2:0] p, n, c;
    p = prv[e]; n = nxt[e];
    if (valid_id(p)) begin
      if (kid[p] == e) kid[p] = n;
      else nxt[p] = n;
      if (valid_id(n)) prv[n] = p;
    end
    nxt[e] = NilId;
    prv[e] = NilId;
    c = kid[e];
    if (valid_id(c)) begin
      c = pair_up(c);
      root = link(root, c);
      kid[e] = NilId;
    end
  endfunction

  function automatic void push_later(logic [2:0] b, logic [63:0] t);
    logic [63:0] nd;
    nd = add_sat(t, lat(b));
    if (nd > dl[b]) begin
      dl[b] = nd;
      if (root != b) begin unlink(b); root = link(root, b); end
      else if (valid_id(kid[b])) begin pop_root(b); root = link(root, b); end
    end
  endfunction

  function automatic void clear_state();
    for (int b = 0; b < NB; b++) begin
      dl[b] = '0; run_f[b] = 0; starv_f[b] = 0; starv_t0[b] = '0;
      budget[b] = wbud(b); wend[b] = TimeMax;
      kid[b] = NilId; nxt[b] = NilId; prv[b] = NilId;
    end
    run_map = '0; warp_map = '0; root = NilId;
  endfunction

  function automatic outcome_t pick(logic [63:0] t);
    outcome_t o;
    logic [2:0] e, hi, wi;
    logic [63:0] we;
    o = '0;
    forever begin
      e = root;
      if (!valid_id(e)) return o;
      if (starv_f[e] && t >= add_sat(starv_t0[e], quantum(e))) begin
        starv_f[e] = 0; starv_t0[e] = '0;
        push_later(e, t);
        continue;
      end
      hi = lowest(run_map);
      wi = lowest(warp_map);
      if (!(valid_id(wi) && wi < e)) begin
        if (!starv_f[e]) begin
          if (hi < e) begin starv_f[e] = 1; starv_t0[e] = t; end
          else begin
            push_later(e, t);
            budget[e] = wbud(e);
            wend[e] = TimeMax;
            if (budget[e] != 0) warp_map[e] = 1'b1;
          end
        end
        o.sel_valid = 1; o.sel_bucket = e;
        o.sel_reason = starv_f[e] ? ReasonStarve : ReasonEdf;
        return o;
      end
      if (wend[wi] == TimeMax || wend[wi] > t) begin
        if (wend[wi] == TimeMax) begin
          we = add_sat(t, {48'd0, budget[wi]});
          wend[wi] = (we == TimeMax) ? TimeMax - 64'd1 : we;
        end
        push_later(wi, t);
        o.sel_valid = 1; o.sel_bucket = wi; o.sel_reason = ReasonWarp;
        return o;
      end
      budget[wi] = '0;
      warp_map[wi] = 1'b0;
    end
  endfunction

  function automatic outcome_t apply_request(logic [1:0] kind, logic [2:0] b, logic [63:0] t);
    outcome_t o;
    logic [63:0] r;
    o = '0;
    if (kind == ReqRunnable) begin
      if (!valid_id(b) || run_f[b]) begin o.req_error = 1; return o; end
      run_f[b] = 1;
      run_map[b] = 1'b1;
      if (!starv_f[b]) dl[b] = add_sat(t, lat(b));
      nxt[b] = NilId; prv[b] = NilId; kid[b] = NilId;
      root = link(root, b);
      if (budget[b] != 0) warp_map[b] = 1'b1;
    end else if (kind == ReqEmpty) begin
      if (!valid_id(b) || !run_f[b]) begin o.req_error = 1; return o; end
      run_f[b] = 0;
      run_map[b] = 1'b0;
      if (root == b) pop_root(b);
      else unlink(b);
      warp_map[b] = 1'b0;
      if (wend[b] != TimeMax) begin
        r = wend[b] > t ? wend[b] - t : 64'd0;
        budget[b] = r > 64'hFFFF ? 16'hFFFF : r[15:0];
      end
    end else if (kind == ReqSelect) begin
      o = pick(t);
    end
    return o;
  endfunction
endpackage

/* verif/edf_bucket_scheduler_warp_starvation_test.sv */
// Test top for the EDF bucket scheduler: directed and random request streams,
// results checked against edfbs_sched_model. Also needs edfbs_pkg and edfbs_if.
`timescale 1ns / 100ps
module edf_bucket_scheduler_warp_starvation_test;
  import edfbs_pkg::*;
  import edfbs_sched_model::*;

  logic clk;
  logic rst;
  int   mismatches;
  logic [63:0] now_us;
  outcome_t pending[$];

  edfbs_req_if req ();
  edfbs_res_if res ();

  edf_bucket_scheduler_warp_starvation DUT (.clk(clk), .rst(rst), .req(req), .res(res));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Hold each beat until taken, then advance the prediction.
  task automatic send_request(logic [1:0] kind, logic [2:0] b, logic [63:0] t);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(negedge clk);
    end
    req.valid <= 1;
    req.req_type <= kind;
    req.bucket_id <= b;
    req.time_us <= t;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending.push_back(apply_request(kind, b, t));
    @(negedge clk);
  endtask

  initial begin
    res.ready = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 8) begin
        res.ready <= 0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        res.ready <= ($urandom_range(0, 99) < 80);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && res.valid && res.ready) begin
      if (pending.size() == 0) begin
        report("unexpected beat", 8'd0, 8'd0);
      end else begin
        w = pending.pop_front();
        if (res.sel_valid !== w.sel_valid)
          report("sel_valid", 8'(res.sel_valid), 8'(w.sel_valid));
        if (res.sel_bucket !== w.sel_bucket)
          report("sel_bucket", 8'(res.sel_bucket), 8'(w.sel_bucket));
        if (res.sel_reason !== w.sel_reason)
          report("sel_reason", 8'(res.sel_reason), 8'(w.sel_reason));
        if (res.req_error !== w.req_error)
          report("req_error", 8'(res.req_error), 8'(w.req_error));
      end
    end
  end

  task automatic step_time(int unsigned maxd);
    logic [63:0] d;
    d = 64'($urandom_range(0, maxd));
    now_us = (now_us > TimeMax - d) ? TimeMax : now_us + d;
  endtask

  task automatic test_errors_and_noop();
    send_request(ReqSelect, 3'd0, now_us);
    send_request(ReqEmpty, 3'd2, now_us);
    send_request(ReqRunnable, 3'd5, now_us);
    send_request(ReqEmpty, 3'd7, now_us);
    send_request(ReqNoop, 3'd6, now_us);
    send_request(ReqRunnable, 3'd4, now_us);
    send_request(ReqRunnable, 3'd4, now_us);
    send_request(ReqEmpty, 3'd4, now_us);
  endtask

  task automatic test_warp_and_starvation();
    for (int b = 0; b < NB; b++) send_request(ReqRunnable, 3'(b), now_us);
    send_request(ReqSelect, 3'd0, now_us);
    send_request(ReqSelect, 3'd0, now_us + 64'd100);
    now_us += 64'd20000;
    send_request(ReqSelect, 3'd0, now_us);
    send_request(ReqEmpty, 3'd0, now_us);
    send_request(ReqSelect, 3'd0, now_us);
    now_us += 64'd300000;
    send_request(ReqSelect, 3'd0, now_us);
    send_request(ReqEmpty, 3'd3, now_us);
    send_request(ReqRunnable, 3'd3, now_us - 64'd5);
    for (int b = 1; b < NB; b++) send_request(ReqEmpty, 3'(b), now_us);
  endtask

  task automatic test_time_saturation();
    now_us = TimeMax - 64'd40000;
    send_request(ReqRunnable, 3'd1, now_us);
    send_request(ReqRunnable, 3'd4, now_us);
    send_request(ReqSelect, 3'd0, now_us);
    now_us = TimeMax - 64'd1;
    send_request(ReqSelect, 3'd0, now_us);
    now_us = TimeMax;
    send_request(ReqSelect, 3'd0, now_us);
    send_request(ReqEmpty, 3'd1, now_us);
    send_request(ReqEmpty, 3'd4, now_us);
  endtask

  // Mostly well-formed toggles with selects; some bad ids and no-ops as noise.
  task automatic test_random_traffic(int count);
    int r;
    logic [2:0] b;
    logic [63:0] t;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) step_time(200000);
      else if (r < 30) step_time(3000);
      else step_time(400);
      t = now_us;
      // Occasionally present a time from the past.
      if ($urandom_range(0, 99) < 3 && t > 64'd50000) t = t - 64'd50000;
      r = $urandom_range(0, 99);
      if (r < 45) send_request(ReqSelect, 3'($urandom), t);
      else if (r < 92) begin
        b = 3'($urandom_range(0, NB - 1));
        send_request(run_f[b] ? ReqEmpty : ReqRunnable, b, t);
      end else if (r < 96) send_request(2'($urandom_range(0, 1)), 3'($urandom), t);
      else send_request(ReqNoop, 3'($urandom), t);
    end
  endtask

  task automatic test_random_wide_time(int count);
    now_us = {$urandom, $urandom} >> $urandom_range(0, 63);
    test_random_traffic(count);
    now_us = 64'hFFFF_FFFF_FFFF_0000;
    test_random_traffic(count);
  endtask

  initial begin
    int waited;
    rst = 1;
    mismatches = 0;
    now_us = 0;
    req.valid = 0;
    req.req_type = ReqRunnable;
    req.bucket_id = 0;
    req.time_us = 0;
    clear_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_errors_and_noop();
    test_warp_and_starvation();
    test_time_saturation();
    // Start the random part from an empty, fresh-timed scheduler.
    for (int b = 0; b < NB; b++) if (run_f[b]) send_request(ReqEmpty, 3'(b), now_us);
    now_us = 64'd1000;
    test_random_traffic(560);
    test_random_wide_time(60);
    req.valid <= 0;
    waited = 0;
    while (pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/edfbs_pkg.sv
hdl/edfbs_if.sv
hdl/edfbs_datapath.sv
hdl/edfbs_ctrl.sv
hdl/edf_bucket_scheduler_warp_starvation.sv
verif/edfbs_sched_model.sv
verif/edf_bucket_scheduler_warp_starvation_test.sv
